// File: rtl/afc_pkg.sv
package afc_pkg;

  localparam int unsigned NumPlanesDef = 6;
  localparam int unsigned PlaneRegs    = 6;
  localparam int unsigned MaxPlanes    = 8;
  localparam int unsigned CfgAddrW     = 3;
  localparam int unsigned PlaneW       = 64;
  localparam int unsigned CoordW       = 16;
  localparam int unsigned NumAxes      = 3;
  localparam int unsigned InDataW      = 10 * CoordW;
  localparam int unsigned OutDataW     = 8;

  // Q16.16 world coordinate: 33-bit product plus the shifted position.
  localparam int unsigned WorldW = 34;
  // Q1.14 normal times Q16.16 coordinate.
  localparam int unsigned ProdW  = CoordW + WorldW;
  // Three products plus the offset scaled to 30 fraction bits.
  localparam int unsigned DistW  = ProdW + 2;
  localparam int unsigned OffShift = 22;
  localparam int unsigned PosShift = 8;

  typedef logic [WorldW-1:0] world_coord_t;

  typedef struct packed {
    world_coord_t [NumAxes-1:0] lo;
    world_coord_t [NumAxes-1:0] hi;
  } world_box_t;

endpackage

// File: rtl/afc_xform.sv
module afc_xform (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [afc_pkg::InDataW-1:0] in_data_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output afc_pkg::world_box_t        out_box_o
);
  import afc_pkg::*;

  logic       valid_q;
  logic       ready;
  world_box_t box_d, box_q;
  logic signed [CoordW:0] scale;

  assign ready = !valid_q || out_ready_i;
  assign in_ready_o = ready;
  assign scale = $signed({1'b0, in_data_i[6*CoordW +: CoordW]});

  always_comb begin
    for (int a = 0; a < NumAxes; a++) begin
      logic [CoordW-1:0] pos;
      logic signed [WorldW-1:0] pos_w;
      logic signed [WorldW-1:0] lo_w;
      logic signed [WorldW-1:0] hi_w;
      pos   = in_data_i[(7 + a)*CoordW +: CoordW];
      pos_w = $signed({{(WorldW-CoordW-PosShift){pos[CoordW-1]}}, pos, {PosShift{1'b0}}});
      lo_w  = $signed(in_data_i[a*CoordW +: CoordW]) * scale;
      hi_w  = $signed(in_data_i[(3 + a)*CoordW +: CoordW]) * scale;
      box_d.lo[a] = lo_w + pos_w;
      box_d.hi[a] = hi_w + pos_w;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready && in_valid_i) begin
      box_q <= box_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_box_o   = box_q;

endmodule

// File: rtl/afc_plane_cell.sv
module afc_plane_cell (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [afc_pkg::PlaneW-1:0] plane_i,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  afc_pkg::world_box_t        in_box_i,
  input  logic                       in_vis_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output afc_pkg::world_box_t        out_box_o,
  output logic                       out_vis_o
);
  import afc_pkg::*;

  logic ready_a, ready_b;
  logic valid_a_q, valid_b_q;
  logic vis_a_q, vis_b_q;
  world_box_t box_a_q, box_b_q;
  logic [NumAxes-1:0][ProdW-1:0] prod_d, prod_a_q;
  logic [CoordW-1:0] offset;
  logic signed [DistW-1:0] plane_dist;

  assign ready_b    = !valid_b_q || out_ready_i;
  assign ready_a    = !valid_a_q || ready_b;
  assign in_ready_o = ready_a;
  assign offset     = plane_i[NumAxes*CoordW +: CoordW];

  // Positive vertex: the min corner on axes where the normal points negative.
  always_comb begin
    for (int a = 0; a < NumAxes; a++) begin
      logic [CoordW-1:0] n;
      logic signed [ProdW-1:0] p;
      n = plane_i[a*CoordW +: CoordW];
      if (n[CoordW-1]) begin
        p = $signed(n) * $signed(in_box_i.lo[a]);
      end else begin
        p = $signed(n) * $signed(in_box_i.hi[a]);
      end
      prod_d[a] = p;
    end
  end

  always_comb begin
    plane_dist = $signed({{(DistW-CoordW-OffShift){offset[CoordW-1]}}, offset,
                          {OffShift{1'b0}}});
    for (int a = 0; a < NumAxes; a++) begin
      plane_dist = plane_dist + $signed({{(DistW-ProdW){prod_a_q[a][ProdW-1]}}, prod_a_q[a]});
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_a_q <= 1'b0;
      valid_b_q <= 1'b0;
    end else begin
      if (ready_a) begin
        valid_a_q <= in_valid_i;
      end
      if (ready_b) begin
        valid_b_q <= valid_a_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_a && in_valid_i) begin
      prod_a_q <= prod_d;
      box_a_q  <= in_box_i;
      vis_a_q  <= in_vis_i;
    end
    if (ready_b && valid_a_q) begin
      box_b_q <= box_a_q;
      vis_b_q <= vis_a_q && !plane_dist[DistW-1];
    end
  end

  assign out_valid_o = valid_b_q;
  assign out_box_o   = box_b_q;
  assign out_vis_o   = vis_b_q;

endmodule

// File: rtl/aabb_frustum_cull.sv
// Channel   Direction  Payload
// s_axis    in         tdata: box corners, scale and position, 10 x 16 bits
// m_axis    out        tdata: visible flag in bit 0
// cfg       in         write enable, plane register index, 64-bit plane word
//
// One item is accepted per cycle unless back-pressure from m_axis_tready
// stalls it. The transform stage registers the world-space corners, then
// each plane cell registers its three vertex products, then the sum's sign.
// Every stage has its own valid bit, so bubbles close up under a stall and
// the last cell's register holds a result until it is taken.
// Reset clears the plane registers, so every box reads visible until written.
module aabb_frustum_cull #(
  parameter int unsigned NUM_PLANES = afc_pkg::NumPlanesDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  // box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z,
  // object_scale, offset_x, offset_y, offset_z (16 bits each, lowest first)
  input  logic [afc_pkg::InDataW-1:0]  s_axis_tdata,
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // visible in bit 0, upper bits zero
  output logic [afc_pkg::OutDataW-1:0] m_axis_tdata,
  input  logic                         cfg_we_i,
  input  logic [afc_pkg::CfgAddrW-1:0] cfg_addr_i,
  input  logic [afc_pkg::PlaneW-1:0]   cfg_wdata_i
);
  import afc_pkg::*;

  logic [PlaneRegs-1:0][PlaneW-1:0] plane_q;

  logic       link_valid [NUM_PLANES+1];
  logic       link_ready [NUM_PLANES+1];
  world_box_t link_box   [NUM_PLANES+1];
  logic       link_vis   [NUM_PLANES+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      plane_q <= '0;
    end else if (cfg_we_i && (32'(cfg_addr_i) < PlaneRegs)) begin
      plane_q[cfg_addr_i] <= cfg_wdata_i;
    end
  end

  afc_xform u_xform (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_data_i   (s_axis_tdata),
    .out_valid_o (link_valid[0]),
    .out_ready_i (link_ready[0]),
    .out_box_o   (link_box[0])
  );

  assign link_vis[0] = 1'b1;

  for (genvar p = 0; p < NUM_PLANES; p++) begin : g_cell
    logic [PlaneW-1:0] plane;
    // Slots past the plane registers see a zero plane, which never rejects.
    if (p < PlaneRegs) begin : g_reg
      assign plane = plane_q[p];
    end else begin : g_zero
      assign plane = '0;
    end

    afc_plane_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .plane_i     (plane),
      .in_valid_i  (link_valid[p]),
      .in_ready_o  (link_ready[p]),
      .in_box_i    (link_box[p]),
      .in_vis_i    (link_vis[p]),
      .out_valid_o (link_valid[p+1]),
      .out_ready_i (link_ready[p+1]),
      .out_box_o   (link_box[p+1]),
      .out_vis_o   (link_vis[p+1])
    );
  end

  assign link_ready[NUM_PLANES] = m_axis_tready;
  assign m_axis_tvalid = link_valid[NUM_PLANES];
  assign m_axis_tdata  = {{(OutDataW-1){1'b0}}, link_vis[NUM_PLANES]};

endmodule
